/* rtl/core/tkgr_pkg.sv */
// Package of constants, codes and types shared by the registry unit.
package tkgr_pkg;
    localparam int MaxEntries = 64;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CntW = IdxW + 1;
    localparam int MemDepth = MaxEntries * MaxEntries;
    localparam int MemAw = 2 * IdxW;
    localparam int KeyW = 16;
    localparam int QDepth = 2;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_LOOK_F = 3'd1,
        CMD_LOOK_B = 3'd2,
        CMD_FIND   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // One classified command as it passes from the front to the back part.
    typedef struct packed {
        logic [2:0]      cmd;
        logic [KeyW-1:0] fkey;
        logic [KeyW-1:0] bkey;
        logic [5:0]      gsel;
        logic [5:0]      rsel;
    } t_job;

    typedef struct packed {
        logic [1:0]      status;
        logic [5:0]      entry_index;
        logic [5:0]      field_group;
        logic [5:0]      field_rank;
        logic [5:0]      bin_group;
        logic [5:0]      bin_rank;
        logic [KeyW-1:0] found_name_a;
        logic [KeyW-1:0] found_name_b;
    } t_res;
endpackage

/* rtl/core/tkgr_if.sv */
// Valid/ready channel interfaces for the command and result words.
interface tkgr_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [15:0] field_key;
    logic [15:0] bin_key;
    logic [5:0] group_sel;
    logic [5:0] rank_sel;
    modport source (output valid, cmd, field_key, bin_key, group_sel, rank_sel, input ready);
    modport sink (input valid, cmd, field_key, bin_key, group_sel, rank_sel, output ready);
endinterface

interface tkgr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [5:0]  entry_index;
    logic [5:0]  field_group;
    logic [5:0]  field_rank;
    logic [5:0]  bin_group;
    logic [5:0]  bin_rank;
    logic [15:0] found_name_a;
    logic [15:0] found_name_b;
    modport source (output valid, status, entry_index, field_group, field_rank, bin_group,
        bin_rank, found_name_a, found_name_b, input ready);
    modport sink (input valid, status, entry_index, field_group, field_rank, bin_group,
        bin_rank, found_name_a, found_name_b, output ready);
endinterface

/* rtl/core/tkgr_ram.sv */
// Generic single-port-write, one-read RAM with registered read data.
module tkgr_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/core/tkgr_front.sv */
// Front part: takes command words and queues them for the back part.
module tkgr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tkgr_cmd_if.sink           cmd_in,
    output logic               o_job_valid,
    output tkgr_pkg::t_job     o_job,
    input  logic               i_job_take
);
    localparam int PtrW = $clog2(tkgr_pkg::QDepth);

    tkgr_pkg::t_job  r_q [tkgr_pkg::QDepth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [PtrW:0]   r_cnt;
    logic            push, pop;
    tkgr_pkg::t_job  w_job;

    assign cmd_in.ready = (r_cnt < (PtrW+1)'(tkgr_pkg::QDepth));
    assign push = cmd_in.valid && cmd_in.ready;
    assign pop  = i_job_take && (r_cnt != '0);
    assign o_job_valid = (r_cnt != '0);
    assign o_job = r_q[r_rp];

    always_comb begin
        w_job.cmd  = cmd_in.cmd;
        w_job.fkey = cmd_in.field_key;
        w_job.bkey = cmd_in.bin_key;
        w_job.gsel = cmd_in.group_sel;
        w_job.rsel = cmd_in.rank_sel;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    ap_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PtrW+1)'(tkgr_pkg::QDepth))
        else $error("command queue overflow");
    ap_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> r_cnt != '0)
        else $error("pop from empty queue");
    ap_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count slip");
endmodule

/* rtl/core/tkgr_back.sv */
// Back part: carries out commands against the stores, one at a time.
module tkgr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  tkgr_pkg::t_job i_job,
    output logic           o_job_take,
    tkgr_res_if.source     res_out
);
    localparam int IW = tkgr_pkg::IdxW;
    localparam int CW = tkgr_pkg::CntW;
    localparam int AW = tkgr_pkg::MemAw;
    localparam int KW = tkgr_pkg::KeyW;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FSCAN = 8'b0000_0010, // scan field dictionary
        S_BSCAN = 8'b0000_0100, // scan bin dictionary
        S_SIZE  = 8'b0000_1000, // read group sizes
        S_UPD   = 8'b0001_0000, // write stores
        S_ESCAN = 8'b0010_0000, // scan entries for find
        S_LOOK  = 8'b0100_0000, // member and name reads
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    tkgr_pkg::t_job r_job;
    tkgr_pkg::t_res r_res;
    tkgr_pkg::t_res w_res_full, w_res_miss;
    logic [CW-1:0] r_ecnt, r_fcnt, r_bcnt;
    logic [CW-1:0] r_i;           // scan index
    logic          r_rdv;         // read data of index r_i-1 valid
    logic [1:0]    r_ph;
    logic [IW-1:0] r_fg, r_bg;
    logic          r_fhit, r_bhit;
    logic [IW-1:0] r_n;

    // Store ports
    logic          fk_we, bk_we, fs_we, bs_we, fm_we, bm_we, en_we;
    logic [IW-1:0] fk_ra, bk_ra, fs_ra, bs_ra, en_ra;
    logic [KW-1:0] fk_rd, bk_rd, ef_rd, eb_rd;
    logic [CW-1:0] fs_rd, bs_rd, fs_wd, bs_wd;
    logic [AW-1:0] fm_wa, bm_wa, fm_ra, bm_ra;
    logic [IW-1:0] fm_rd, bm_rd;
    logic [IW-1:0] fs_wa, bs_wa;

    tkgr_ram #(.Width(KW), .Depth(tkgr_pkg::MaxEntries)) u_fkey (.i_clk,
        .i_we(fk_we), .i_waddr(r_fg), .i_wdata(r_job.fkey), .i_raddr(fk_ra), .o_rdata(fk_rd));
    tkgr_ram #(.Width(KW), .Depth(tkgr_pkg::MaxEntries)) u_bkey (.i_clk,
        .i_we(bk_we), .i_waddr(r_bg), .i_wdata(r_job.bkey), .i_raddr(bk_ra), .o_rdata(bk_rd));
    tkgr_ram #(.Width(CW), .Depth(tkgr_pkg::MaxEntries)) u_fsize (.i_clk,
        .i_we(fs_we), .i_waddr(fs_wa), .i_wdata(fs_wd), .i_raddr(fs_ra), .o_rdata(fs_rd));
    tkgr_ram #(.Width(CW), .Depth(tkgr_pkg::MaxEntries)) u_bsize (.i_clk,
        .i_we(bs_we), .i_waddr(bs_wa), .i_wdata(bs_wd), .i_raddr(bs_ra), .o_rdata(bs_rd));
    tkgr_ram #(.Width(IW), .Depth(tkgr_pkg::MemDepth)) u_fmem (.i_clk,
        .i_we(fm_we), .i_waddr(fm_wa), .i_wdata(r_n), .i_raddr(fm_ra), .o_rdata(fm_rd));
    tkgr_ram #(.Width(IW), .Depth(tkgr_pkg::MemDepth)) u_bmem (.i_clk,
        .i_we(bm_we), .i_waddr(bm_wa), .i_wdata(r_n), .i_raddr(bm_ra), .o_rdata(bm_rd));
    tkgr_ram #(.Width(KW), .Depth(tkgr_pkg::MaxEntries)) u_ename_f (.i_clk,
        .i_we(en_we), .i_waddr(r_n), .i_wdata(r_job.fkey), .i_raddr(en_ra), .o_rdata(ef_rd));
    tkgr_ram #(.Width(KW), .Depth(tkgr_pkg::MaxEntries)) u_ename_b (.i_clk,
        .i_we(en_we), .i_waddr(r_n), .i_wdata(r_job.bkey), .i_raddr(en_ra), .o_rdata(eb_rd));

    logic [CW-1:0] fr_new, br_new;   // new sizes after the insert
    logic [IW-1:0] fr, br;
    logic          fsel;

    always_comb begin
        fr = r_fhit ? ((fs_rd >= CW'(tkgr_pkg::MaxEntries)) ?
                IW'(tkgr_pkg::MaxEntries - 1) : fs_rd[IW-1:0]) : '0;
        br = r_bhit ? ((bs_rd >= CW'(tkgr_pkg::MaxEntries)) ?
                IW'(tkgr_pkg::MaxEntries - 1) : bs_rd[IW-1:0]) : '0;
        fr_new = CW'(fr) + 1'b1;
        br_new = CW'(br) + 1'b1;
        fsel = (r_job.cmd == tkgr_pkg::CMD_LOOK_F);
    end

    // Result words for a full table and for an unknown command.
    always_comb begin
        w_res_full = '0;
        w_res_full.status = tkgr_pkg::ST_FULL;
        w_res_miss = '0;
        w_res_miss.status = tkgr_pkg::ST_MISS;
    end

    // Read addresses follow the scan index; lookups drive group and rank.
    always_comb begin
        fk_ra = r_i[IW-1:0];
        bk_ra = r_i[IW-1:0];
        en_ra = (r_state == S_LOOK) ? (fsel ? fm_rd : bm_rd) : r_i[IW-1:0];
        fs_ra = (r_state == S_SIZE) ? r_fg : r_job.gsel[IW-1:0];
        bs_ra = (r_state == S_SIZE) ? r_bg : r_job.gsel[IW-1:0];
        fm_ra = {r_job.gsel[IW-1:0], r_job.rsel[IW-1:0]};
        bm_ra = {r_job.gsel[IW-1:0], r_job.rsel[IW-1:0]};
        fk_we = (r_state == S_UPD) && !r_fhit;
        bk_we = (r_state == S_UPD) && !r_bhit;
        fs_we = (r_state == S_UPD);
        bs_we = (r_state == S_UPD);
        fm_we = (r_state == S_UPD);
        bm_we = (r_state == S_UPD);
        en_we = (r_state == S_UPD);
        fs_wa = r_fg;
        bs_wa = r_bg;
        fs_wd = fr_new;
        bs_wd = br_new;
        fm_wa = {r_fg, fr};
        bm_wa = {r_bg, br};
    end

    assign o_job_take = (r_state == S_IDLE);
    assign res_out.valid        = (r_state == S_OUT);
    assign res_out.status       = r_res.status;
    assign res_out.entry_index  = r_res.entry_index;
    assign res_out.field_group  = r_res.field_group;
    assign res_out.field_rank   = r_res.field_rank;
    assign res_out.bin_group    = r_res.bin_group;
    assign res_out.bin_rank     = r_res.bin_rank;
    assign res_out.found_name_a = r_res.found_name_a;
    assign res_out.found_name_b = r_res.found_name_b;

    logic [CW-1:0] fgn, bgn;
    always_comb begin
        fgn = (r_fcnt >= CW'(tkgr_pkg::MaxEntries)) ? CW'(tkgr_pkg::MaxEntries - 1) : r_fcnt;
        bgn = (r_bcnt >= CW'(tkgr_pkg::MaxEntries)) ? CW'(tkgr_pkg::MaxEntries - 1) : r_bcnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ecnt  <= '0;
            r_fcnt  <= '0;
            r_bcnt  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_i   <= '0;
                        r_rdv <= 1'b0;
                        r_ph  <= '0;
                        r_fhit <= 1'b0;
                        r_bhit <= 1'b0;
                        r_n   <= r_ecnt[IW-1:0];
                        unique case (i_job.cmd)
                            tkgr_pkg::CMD_INSERT: begin
                                if (r_ecnt >= CW'(tkgr_pkg::MaxEntries)) begin
                                    r_res <= w_res_full;
                                    r_state <= S_OUT;
                                end else begin
                                    r_res <= '0;
                                    r_state <= S_FSCAN;
                                end
                            end
                            tkgr_pkg::CMD_LOOK_F, tkgr_pkg::CMD_LOOK_B: begin
                                r_res <= '0;
                                r_state <= S_LOOK;
                            end
                            tkgr_pkg::CMD_FIND: begin
                                r_res <= '0;
                                r_state <= S_ESCAN;
                            end
                            tkgr_pkg::CMD_CLEAR: begin
                                r_res <= '0;
                                r_ecnt <= '0;
                                r_fcnt <= '0;
                                r_bcnt <= '0;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_res <= w_res_miss;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_FSCAN: begin
                    // Address r_i issued; data of r_i-1 arrives now.
                    if (r_rdv && fk_rd == r_job.fkey) begin
                        r_fhit <= 1'b1;
                        r_fg   <= IW'(r_i - 1'b1);
                        r_i <= '0; r_rdv <= 1'b0; r_state <= S_BSCAN;
                    end else if (r_i >= r_fcnt) begin
                        r_fg <= fgn[IW-1:0];
                        r_i <= '0; r_rdv <= 1'b0; r_state <= S_BSCAN;
                    end else begin
                        r_i <= r_i + 1'b1; r_rdv <= 1'b1;
                    end
                end
                S_BSCAN: begin
                    if (r_rdv && bk_rd == r_job.bkey) begin
                        r_bhit <= 1'b1;
                        r_bg   <= IW'(r_i - 1'b1);
                        r_state <= S_SIZE; r_ph <= '0;
                    end else if (r_i >= r_bcnt) begin
                        r_bg <= bgn[IW-1:0];
                        r_state <= S_SIZE; r_ph <= '0;
                    end else begin
                        r_i <= r_i + 1'b1; r_rdv <= 1'b1;
                    end
                end
                S_SIZE: begin
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 2'd1) r_state <= S_UPD;
                end
                S_UPD: begin
                    if (!r_fhit) r_fcnt <= fgn + 1'b1;
                    if (!r_bhit) r_bcnt <= bgn + 1'b1;
                    r_ecnt <= r_ecnt + 1'b1;
                    r_res.entry_index <= 6'(r_n);
                    r_res.field_group <= 6'(r_fg);
                    r_res.field_rank  <= 6'(fr);
                    r_res.bin_group   <= 6'(r_bg);
                    r_res.bin_rank    <= 6'(br);
                    r_state <= S_OUT;
                end
                S_ESCAN: begin
                    if (r_rdv && ef_rd == r_job.fkey && eb_rd == r_job.bkey) begin
                        r_res.entry_index  <= 6'(r_i - 1'b1);
                        r_res.found_name_a <= ef_rd;
                        r_res.found_name_b <= eb_rd;
                        r_state <= S_OUT;
                    end else if (r_i >= r_ecnt) begin
                        r_res.status <= tkgr_pkg::ST_MISS;
                        r_state <= S_OUT;
                    end else begin
                        r_i <= r_i + 1'b1; r_rdv <= 1'b1;
                    end
                end
                S_LOOK: begin
                    // Phase 0: member and size reads issued; 1: data back,
                    // name read issued; 2: names back.
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 2'd1) begin
                        if ((CW'(r_job.gsel) >= (fsel ? r_fcnt : r_bcnt)) ||
                            (CW'(r_job.rsel) >= (fsel ? fs_rd : bs_rd))) begin
                            r_res.status <= tkgr_pkg::ST_MISS;
                            r_state <= S_OUT;
                        end
                    end else if (r_ph == 2'd2) begin
                        r_res.entry_index  <= 6'(fsel ? fm_rd : bm_rd);
                        r_res.found_name_a <= ef_rd;
                        r_res.found_name_b <= eb_rd;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (res_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    ap_cnt_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_ecnt && r_bcnt <= r_ecnt)
        else $error("group count above entry count");
    ap_ecnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecnt <= CW'(tkgr_pkg::MaxEntries))
        else $error("entry count overflow");
    ap_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |-> !res_out.valid)
        else $error("take while result pending");
endmodule

/* rtl/core/two_key_group_registry_unit.sv */
// Top level of the two-key group registry.
//
// A registry of up to 64 entries, each holding a field name and a bin name,
// with a dictionary of distinct values per column. Command words enter a
// two-deep queue in the front part and are carried out one at a time by the
// back part. An insert scans the field dictionary and then the bin
// dictionary, one stored key a cycle; a find by names scans the entry
// names, one a cycle. Every command gives exactly one result word, held
// in an output register until taken. The stores are block RAMs with
// registered reads and need no clearing pass after reset.
module two_key_group_registry_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkgr_cmd_if.sink    cmd_in,
    tkgr_res_if.source  res_out
);
    logic           job_valid;
    logic           job_take;
    tkgr_pkg::t_job job;

    tkgr_front u_front (
        .i_clk, .i_rst_n, .cmd_in,
        .o_job_valid(job_valid), .o_job(job), .i_job_take(job_take)
    );

    tkgr_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .i_job(job), .o_job_take(job_take), .res_out
    );
endmodule
